// ===== hdl/gaussian_blur_5x5_rgb_top_macros.svh =====
// assertion macros for the 5x5 gaussian blur block
// used by gaussian_blur_5x5_rgb_top, expects clk_i and rst_ni in scope
`ifndef GAUSSIAN_BLUR_5X5_RGB_TOP_MACROS_SVH
`define GAUSSIAN_BLUR_5X5_RGB_TOP_MACROS_SVH

// condition holds at every clock edge out of reset
`define GB5_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("gb5 assertion failed");

// trigger at one edge implies consequence at the next edge
`define GB5_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("gb5 assertion failed");

`endif

// ===== hdl/gb5_pkg.sv =====
// shared types, constants and helper functions of the 5x5 gaussian blur
// no dependencies
`timescale 1ns / 1ps

package gb5_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int PIX_W        = 24;
  localparam int KSIZE        = 5;
  localparam int HIST         = KSIZE - 1;
  localparam int LS_W         = HIST * PIX_W;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int FW_W         = 12;
  localparam int FH_W         = 13;
  localparam int CFG_W        = 13;
  localparam int ROW_W        = 13;
  localparam int RSUM_W       = 13;
  localparam int TSUM_W       = 14;
  // floor(x / 13) == (x * DIV_MUL) >> 16 for x below 4096
  localparam logic [12:0] DIV_MUL = 13'd5042;

  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] in_ch0;
    logic [7:0] in_ch1;
    logic [7:0] in_ch2;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic       end_of_row;
    logic       end_of_frame;
  } out_item_t;

  // one column of the window, index is the row (0 oldest)
  typedef logic [KSIZE-1:0][PIX_W-1:0] col_t;

  // border distances, each saturated at two
  typedef struct packed {
    logic [1:0] lx;
    logic [1:0] rx;
    logic [1:0] ty;
    logic [1:0] by;
  } edge_t;

  typedef struct packed {
    logic              go;
    logic              produce;
    logic [PIX_W-1:0]  pix;
    logic [ADDR_W-1:0] addr;
    edge_t             edges;
    logic              eor;
    logic              eof;
  } s1_t;

  typedef struct packed {
    logic  valid;
    edge_t edges;
    logic  eor;
    logic  eof;
  } s2_t;

  function automatic logic [3:0] kweight(input int dr, input int dc);
    logic [3:0] base;
    logic [3:0] res;
    begin
      base = (dc == 2) ? 4'd2 : ((dc == 1 || dc == 3) ? 4'd1 : 4'd1);
      if (dr == 2) begin
        res = (dc == 2) ? 4'd8 : ((dc == 1 || dc == 3) ? 4'd4 : 4'd2);
      end else if (dr == 1 || dr == 3) begin
        res = (dc == 2) ? 4'd4 : ((dc == 1 || dc == 3) ? 4'd2 : 4'd1);
      end else begin
        res = base;
      end
      return res;
    end
  endfunction

  // window index for kernel offset k, clamped to the frame border
  function automatic logic [2:0] tap_sel(input int k, input logic [1:0] lo,
                                         input logic [1:0] hi);
    int lim_lo;
    int lim_hi;
    int r;
    begin
      lim_lo = 2 - int'(lo);
      lim_hi = 2 + int'(hi);
      r = k;
      if (r < lim_lo) r = lim_lo;
      if (r > lim_hi) r = lim_hi;
      return 3'(r);
    end
  endfunction

endpackage

// ===== hdl/gb5_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module gb5_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/gb5_wcell.sv =====
// one window column cell: holds a five-pixel column and hands it on
// depends on gb5_pkg
`timescale 1ns / 1ps

module gb5_wcell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  gb5_pkg::col_t col_i,
  output gb5_pkg::col_t col_o
);

  gb5_pkg::col_t col_q;

  // load neighbor column on each window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ===== hdl/gaussian_blur_5x5_rgb_top.sv =====
// channel | handshake            | payload
// in      | in_valid_i/in_stall_o | in_item_i (gb5_pkg::in_item_t)
// out     | out_valid_o/out_stall_i | out_item_o (gb5_pkg::out_item_t)
// cfg     | cfg_we_i             | cfg_index_i, cfg_data_i
//
// one item per cycle while the output register is not stalled; a result is registered at each stage below
// pipeline: position/ram read, column build and window shift, row sums,
// column sum, divide by 52 into the output register
// a stalled output register freezes the whole pipeline and stalls the input
// reset clears positions and window and loads the config defaults; the line store needs no clearing
// top level of the 5x5 gaussian blur; depends on gb5_pkg, gb5_ram, gb5_wcell
`timescale 1ns / 1ps
`include "gaussian_blur_5x5_rgb_top_macros.svh"

module gaussian_blur_5x5_rgb_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gb5_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gb5_pkg::out_item_t          out_item_o,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_index_i,
  input  logic [gb5_pkg::CFG_W-1:0]   cfg_data_i
);

  localparam int AW = gb5_pkg::ADDR_W;
  localparam int RW = gb5_pkg::ROW_W;

  // configuration registers
  logic [gb5_pkg::FW_W-1:0] frame_width_q;
  logic [gb5_pkg::FH_W-1:0] frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= gb5_pkg::FW_RESET;
      frame_height_q <= gb5_pkg::FH_RESET;
    end else if (cfg_we_i) begin
      unique case (gb5_pkg::cfg_reg_e'(cfg_index_i))
        gb5_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[gb5_pkg::FW_W-1:0];
        gb5_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic out_valid_q;
  logic en;
  logic acc;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign acc        = in_valid_i && en;

  // positions
  logic [AW-1:0] in_col_q, out_col_q;
  logic [RW-1:0] in_row_q, out_row_q;

  logic [11:0] w_eff;
  logic [12:0] h_eff;
  logic [11:0] ic, oc, ic_nx, oc_nx, ic_inc, oc_inc;
  logic [RW-1:0] ir, orr, ir_nx, or_nx;
  logic signed [14:0] dd;
  logic phase, ignore, go, produce, eor, eof;
  gb5_pkg::edge_t edges;
  logic [11:0] rem_x;
  logic [12:0] rem_y;

  always_comb begin
    // effective frame size
    if (frame_width_q == '0) w_eff = 12'd1;
    else if (frame_width_q > 12'(gb5_pkg::MAX_WIDTH)) w_eff = 12'(gb5_pkg::MAX_WIDTH);
    else w_eff = frame_width_q;
    if (frame_height_q == '0) h_eff = 13'd1;
    else if (frame_height_q > 13'(gb5_pkg::HEIGHT_LIMIT)) h_eff = 13'(gb5_pkg::HEIGHT_LIMIT);
    else h_eff = frame_height_q;

    // normalize positions
    ic = {1'b0, in_col_q};
    ir = in_row_q;
    if (ic >= w_eff) begin
      ic = '0;
      ir = in_row_q + 13'd1;
    end
    oc  = {1'b0, out_col_q};
    orr = out_row_q;
    if (oc >= w_eff) begin
      oc  = '0;
      orr = out_row_q + 13'd1;
    end
    if (orr >= h_eff) begin
      ic = '0; ir = '0; oc = '0; orr = '0;
    end

    phase  = ir < h_eff;
    ignore = phase && in_item_i.opcode;
    go     = acc && !ignore;

    // input position advance
    ic_inc = ic + 12'd1;
    ic_nx  = ic_inc;
    ir_nx  = ir;
    if (ic_inc >= w_eff) begin
      ic_nx = '0;
      ir_nx = ir + 13'd1;
    end

    // result due once input is two rows and two pixels ahead
    dd = $signed({2'b00, ir}) - $signed({2'b00, orr}) - 15'sd2;
    produce = (dd >= 15'sd2)
           || ((dd == 15'sd1) && ({1'b0, w_eff} + {1'b0, ic} >= {1'b0, oc} + 13'd2))
           || ((dd == 15'sd0) && ({1'b0, ic} >= {1'b0, oc} + 13'd2));

    eor = oc == w_eff - 12'd1;
    eof = eor && (orr == h_eff - 13'd1);

    oc_inc = oc + 12'd1;
    oc_nx  = oc_inc;
    or_nx  = orr;
    if (oc_inc >= w_eff) begin
      oc_nx = '0;
      or_nx = orr + 13'd1;
    end

    // border distances of the result pixel
    rem_x = w_eff - 12'd1 - oc;
    rem_y = h_eff - 13'd1 - orr;
    edges.lx = (oc >= 12'd2) ? 2'd2 : oc[1:0];
    edges.rx = (rem_x >= 12'd2) ? 2'd2 : rem_x[1:0];
    edges.ty = (orr >= 13'd2) ? 2'd2 : orr[1:0];
    edges.by = (rem_y >= 13'd2) ? 2'd2 : rem_y[1:0];
  end

  // position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (acc) begin
      if (go && produce && eof) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else begin
        in_col_q  <= go ? ic_nx[AW-1:0] : ic[AW-1:0];
        in_row_q  <= go ? ir_nx : ir;
        out_col_q <= (go && produce) ? oc_nx[AW-1:0] : oc[AW-1:0];
        out_row_q <= (go && produce) ? or_nx : orr;
      end
    end
  end

  // stage 1: line store read data arrives
  gb5_pkg::s1_t s1_q;
  logic byp_q;
  logic [gb5_pkg::LS_W-1:0] byp_data_q;
  logic [gb5_pkg::LS_W-1:0] ram_rdata, ls_old, ls_wdata;
  logic [gb5_pkg::PIX_W-1:0] pix;
  gb5_pkg::col_t new_col;
  logic shift;

  assign pix = phase ? {in_item_i.in_ch2, in_item_i.in_ch1, in_item_i.in_ch0} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      byp_q <= 1'b0;
    end else if (en) begin
      s1_q.go      <= go;
      s1_q.produce <= produce;
      s1_q.pix     <= pix;
      s1_q.addr    <= ic[AW-1:0];
      s1_q.edges   <= edges;
      s1_q.eor     <= eor;
      s1_q.eof     <= eof;
      byp_q        <= s1_q.go && (s1_q.addr == ic[AW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      byp_data_q <= ls_wdata;
    end
  end

  // column vector and line store write back
  always_comb begin
    ls_old   = byp_q ? byp_data_q : ram_rdata;
    ls_wdata = {ls_old[gb5_pkg::LS_W-gb5_pkg::PIX_W-1:0], s1_q.pix};
    for (int k = 0; k < gb5_pkg::HIST; k++) begin
      new_col[k] = ls_old[(gb5_pkg::HIST-1-k)*gb5_pkg::PIX_W +: gb5_pkg::PIX_W];
    end
    new_col[gb5_pkg::HIST] = s1_q.pix;
  end

  assign shift = en && s1_q.go;

  gb5_ram #(
    .WIDTH(gb5_pkg::LS_W),
    .DEPTH(gb5_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (shift),
    .waddr_i(s1_q.addr),
    .wdata_i(ls_wdata),
    .re_i   (en),
    .raddr_i(ic[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // window: a row of column cells, newest at the top end
  gb5_pkg::col_t win [gb5_pkg::KSIZE];

  for (genvar c = 0; c < gb5_pkg::KSIZE; c++) begin : g_win
    gb5_wcell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .col_i  ((c == gb5_pkg::KSIZE - 1) ? new_col : win[(c + 1) % gb5_pkg::KSIZE]),
      .col_o  (win[c])
    );
  end

  // stage 2: per-row weighted sums
  gb5_pkg::s2_t s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (en) begin
      s2_q.valid <= s1_q.go && s1_q.produce;
      s2_q.edges <= s1_q.edges;
      s2_q.eor   <= s1_q.eor;
      s2_q.eof   <= s1_q.eof;
    end
  end

  logic [2:0][4:0][gb5_pkg::RSUM_W-1:0] rsum;
  logic [2:0] wr_sel, wc_sel;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int dr = 0; dr < gb5_pkg::KSIZE; dr++) begin
        rsum[ch][dr] = '0;
      end
    end
    wr_sel = '0;
    wc_sel = '0;
    for (int dr = 0; dr < gb5_pkg::KSIZE; dr++) begin
      wr_sel = gb5_pkg::tap_sel(dr, s2_q.edges.ty, s2_q.edges.by);
      for (int dc = 0; dc < gb5_pkg::KSIZE; dc++) begin
        wc_sel = gb5_pkg::tap_sel(dc, s2_q.edges.lx, s2_q.edges.rx);
        for (int ch = 0; ch < 3; ch++) begin
          rsum[ch][dr] = rsum[ch][dr]
            + gb5_pkg::RSUM_W'(win[wc_sel][wr_sel][ch*8 +: 8])
            * gb5_pkg::RSUM_W'(gb5_pkg::kweight(dr, dc));
        end
      end
    end
  end

  // stage 3: row sums registered
  logic s3_valid_q, s3_eor_q, s3_eof_q;
  logic [2:0][4:0][gb5_pkg::RSUM_W-1:0] rsum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsum_q   <= rsum;
      s3_eor_q <= s2_q.eor;
      s3_eof_q <= s2_q.eof;
    end
  end

  // stage 4: total per channel
  logic s4_valid_q, s4_eor_q, s4_eof_q;
  logic [2:0][gb5_pkg::TSUM_W-1:0] tsum, tsum_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tsum[ch] = '0;
      for (int dr = 0; dr < gb5_pkg::KSIZE; dr++) begin
        tsum[ch] = tsum[ch] + gb5_pkg::TSUM_W'(rsum_q[ch][dr]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tsum_q   <= tsum;
      s4_eor_q <= s3_eor_q;
      s4_eof_q <= s3_eof_q;
    end
  end

  // divide by 52: drop two bits, then multiply by the reciprocal of 13
  logic [2:0][7:0] quo;
  logic [24:0] prod [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = 25'(tsum_q[ch][gb5_pkg::TSUM_W-1:2]) * 25'(gb5_pkg::DIV_MUL);
      quo[ch]  = prod[ch][23:16];
    end
  end

  // output register
  gb5_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.out_ch0      <= quo[0];
      out_q.out_ch1      <= quo[1];
      out_q.out_ch2      <= quo[2];
      out_q.end_of_row   <= s4_eor_q;
      out_q.end_of_frame <= s4_eof_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  `GB5_ASSERT_ALWAYS(a_stall_from_out, in_stall_o == (out_valid_o && out_stall_i))
  `GB5_ASSERT_ALWAYS(a_eof_is_eor, !out_valid_o || !out_item_o.end_of_frame || out_item_o.end_of_row)
  `GB5_ASSERT_NEXT(a_last_stage_moves, en && s4_valid_q, out_valid_o)
  `GB5_ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

endmodule

// ===== verif/gaussian_blur_5x5_rgb_top_test.sv =====
// self-checking testbench of the 5x5 gaussian blur, directed frames and frames of random size and content
// depends on gb5_pkg and gaussian_blur_5x5_rgb_top
`timescale 1ns / 1ps

module gaussian_blur_5x5_rgb_top_test;

  localparam int unsigned BLUR_DIV    = 52;
  localparam int          CYCLE_LIMIT = 2000000;
  localparam int unsigned BLUR_W[5][5] = '{'{1, 1, 2, 1, 1}, '{1, 2, 4, 2, 1},
                                           '{2, 4, 8, 4, 2}, '{1, 2, 4, 2, 1},
                                           '{1, 1, 2, 1, 1}};

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  gb5_pkg::in_item_t          in_item_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  gb5_pkg::out_item_t         out_item_o;
  logic                       cfg_we_i = 1'b0;
  logic [0:0]                 cfg_index_i = gb5_pkg::REG_FRAME_WIDTH;
  logic [gb5_pkg::CFG_W-1:0]  cfg_data_i = '0;

  gb5_pkg::in_item_t   pixel_queue[$];
  gb5_pkg::out_item_t  blurred_queue[$];
  int         idle_phase = 0;
  bit         hold_sender = 1'b0;
  int         fail_count = 0;
  int         cycle_count = 0;

  // predictor state
  int unsigned  pred_width = 640, pred_height = 480;
  logic [23:0]  line_rows[4][gb5_pkg::MAX_WIDTH];
  logic [23:0]  win[5][5];                 // [column][row]
  int unsigned  in_col = 0, in_row = 0, out_col = 0, out_row = 0;

  gaussian_blur_5x5_rgb_top u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (line_rows[r, c]) line_rows[r][c] = '0;
    foreach (win[c, r]) win[c][r] = '0;
  end

  function automatic int clamp_to(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // advance the blur state by one item; returns 1 when a pixel comes out
  function automatic bit blur_step(gb5_pkg::in_item_t it, output gb5_pkg::out_item_t res);
    int unsigned w, h, c, sum;
    longint unsigned pos, need;
    logic [23:0] pix, colv[5];
    bit eor, eof;
    int rr, cc;
    w = (pred_width < 1) ? 1 :
        ((pred_width > gb5_pkg::MAX_WIDTH) ? gb5_pkg::MAX_WIDTH : pred_width);
    h = (pred_height < 1) ? 1 :
        ((pred_height > gb5_pkg::HEIGHT_LIMIT) ? gb5_pkg::HEIGHT_LIMIT : pred_height);
    res = '0;
    if (in_col >= w) begin in_col = 0; in_row++; end
    if (out_col >= w) begin out_col = 0; out_row++; end
    if (out_row >= h) begin in_col = 0; in_row = 0; out_col = 0; out_row = 0; end
    pix = '0;
    if (in_row < h) begin
      if (it.opcode) return 1'b0;
      pix = {it.in_ch2, it.in_ch1, it.in_ch0};
    end
    // column vector and line store shift
    c = in_col;
    for (int k = 0; k < 4; k++) colv[k] = line_rows[3 - k][c];
    colv[4] = pix;
    for (int k = 3; k > 0; k--) line_rows[k][c] = line_rows[k - 1][c];
    line_rows[0][c] = pix;
    for (int k = 0; k < 4; k++) win[k] = win[k + 1];
    for (int k = 0; k < 5; k++) win[4][k] = colv[k];
    pos = longint'(in_row) * w + in_col;
    in_col++;
    if (in_col >= w) begin in_col = 0; in_row++; end
    need = (longint'(out_row) + 2) * w + out_col + 2;
    if (pos < need) return 1'b0;
    // weighted sums per channel with border replication
    for (int ch = 0; ch < 3; ch++) begin
      sum = 0;
      for (int dr = 0; dr < 5; dr++) begin
        rr = clamp_to(int'(out_row) + dr - 2, 0, int'(h) - 1) - int'(out_row) + 2;
        for (int dc = 0; dc < 5; dc++) begin
          cc = clamp_to(int'(out_col) + dc - 2, 0, int'(w) - 1) - int'(out_col) + 2;
          sum += BLUR_W[dr][dc] * win[cc][rr][8*ch +: 8];
        end
      end
      sum = sum / BLUR_DIV;
      if (sum > 255) sum = 255;
      if (ch == 0) res.out_ch0 = sum[7:0];
      else if (ch == 1) res.out_ch1 = sum[7:0];
      else res.out_ch2 = sum[7:0];
    end
    eor = (out_col == w - 1);
    eof = eor && (out_row == h - 1);
    res.end_of_row = eor;
    res.end_of_frame = eof;
    out_col++;
    if (out_col >= w) begin out_col = 0; out_row++; end
    if (eof) begin in_col = 0; in_row = 0; out_col = 0; out_row = 0; end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    fail_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // driver: predict on acceptance, then present the next item or idle
  always @(posedge clk_i) begin
    gb5_pkg::out_item_t res;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (blur_step(in_item_i, res)) blurred_queue.push_back(res);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_queue.size() > 0 && !hold_sender &&
            !(idle_phase == 0 && $urandom_range(99) < 38) &&
            !(idle_phase == 1 && $urandom_range(99) < 47)) begin
          in_valid_i <= 1'b1;
          in_item_i <= pixel_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk_i) begin
    gb5_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (blurred_queue.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          want = blurred_queue.pop_front();
          if (out_item_o.out_ch0 !== want.out_ch0)
            report_mismatch("out_ch0", out_item_o.out_ch0, want.out_ch0);
          if (out_item_o.out_ch1 !== want.out_ch1)
            report_mismatch("out_ch1", out_item_o.out_ch1, want.out_ch1);
          if (out_item_o.out_ch2 !== want.out_ch2)
            report_mismatch("out_ch2", out_item_o.out_ch2, want.out_ch2);
          if (out_item_o.end_of_row !== want.end_of_row)
            report_mismatch("end_of_row", out_item_o.end_of_row, want.end_of_row);
          if (out_item_o.end_of_frame !== want.end_of_frame)
            report_mismatch("end_of_frame", out_item_o.end_of_frame, want.end_of_frame);
        end
      end
      out_stall_i <= (idle_phase == 0) ? ($urandom_range(99) < 47) :
                     (idle_phase == 1) ? ($urandom_range(99) < 38) : 1'b0;
    end
  end

  function automatic gb5_pkg::in_item_t rand_pixel();
    gb5_pkg::in_item_t it;
    it.opcode = 1'b0;
    it.in_ch0 = $urandom_range(255);
    it.in_ch1 = $urandom_range(255);
    it.in_ch2 = $urandom_range(255);
    return it;
  endfunction

  function automatic gb5_pkg::in_item_t flush_tick();
    gb5_pkg::in_item_t it;
    it = rand_pixel();
    it.opcode = 1'b1;
    return it;
  endfunction

  // wait until the sender is empty and every predicted pixel has come out
  task automatic drain();
    while (pixel_queue.size() > 0 || in_valid_i || blurred_queue.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(gb5_pkg::cfg_reg_e idx, int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[gb5_pkg::CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gb5_pkg::REG_FRAME_WIDTH) pred_width = val & 32'hFFF;
    else pred_height = val & 32'h1FFF;
    @(posedge clk_i);
  endtask

  // queue one frame: pixels, flush ticks, optional noise and surplus flushes
  task automatic queue_frame(int unsigned w, int unsigned h, bit noisy, ref int count);
    for (int i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(19) == 0) begin
        pixel_queue.push_back(flush_tick());
        count++;
      end
      pixel_queue.push_back(rand_pixel());
      count++;
    end
    for (int i = 0; i < 2 * w + 2; i++) begin
      pixel_queue.push_back((noisy && $urandom_range(7) == 0) ? rand_pixel() : flush_tick());
      count++;
    end
    if (noisy && $urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) pixel_queue.push_back(flush_tick());
    end
  endtask

  // stimulus sequence
  initial begin
    gb5_pkg::in_item_t it;
    int count;
    int unsigned w, h;
    bit held;
    int half;
    count = 0;
    held = 1'b0;
    half = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 5x3 frame with extreme channels, flush during pixels,
    // pixel during flush and surplus flushes
    write_reg(gb5_pkg::REG_FRAME_WIDTH, 5);
    write_reg(gb5_pkg::REG_FRAME_HEIGHT, 3);
    for (int i = 0; i < 15; i++) begin
      it = rand_pixel();
      if (i % 3 == 0) it = '{1'b0, 8'hFF, 8'h00, 8'hFF};
      else if (i % 3 == 1) it = '{1'b0, 8'h00, 8'hFF, 8'h00};
      if (i == 4) pixel_queue.push_back(flush_tick());
      pixel_queue.push_back(it);
    end
    for (int i = 0; i < 12; i++)
      pixel_queue.push_back((i == 3) ? rand_pixel() : flush_tick());
    pixel_queue.push_back(flush_tick());
    pixel_queue.push_back(flush_tick());
    drain();

    // zero registers clamp to a 1x1 frame
    write_reg(gb5_pkg::REG_FRAME_WIDTH, 0);
    write_reg(gb5_pkg::REG_FRAME_HEIGHT, 0);
    queue_frame(1, 1, 1'b0, count);
    drain();

    // random frames, idling pattern changes by thirds
    count = 0;
    while (count < 950) begin
      idle_phase = (count < 317) ? 0 : ((count < 634) ? 1 : 2);
      w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      write_reg(gb5_pkg::REG_FRAME_WIDTH, w);
      write_reg(gb5_pkg::REG_FRAME_HEIGHT, h);
      queue_frame(w, h, 1'b1, count);
      // sender holds once mid-frame until all results are out
      if (!held && count > 400) begin
        held = 1'b1;
        half = pixel_queue.size() / 2;
        while (pixel_queue.size() > half) @(posedge clk_i);
        hold_sender = 1'b1;
        while (blurred_queue.size() > 0 || in_valid_i) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      drain();
    end

    // small noisy frame at full speed
    write_reg(gb5_pkg::REG_FRAME_WIDTH, 2);
    write_reg(gb5_pkg::REG_FRAME_HEIGHT, 2);
    queue_frame(2, 2, 1'b1, count);
    drain();

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/gb5_pkg.sv
hdl/gb5_ram.sv
hdl/gb5_wcell.sv
hdl/gaussian_blur_5x5_rgb_top.sv
verif/gaussian_blur_5x5_rgb_top_test.sv
